// ----- rtl/ppts_pkg.sv -----
// Shared types, codes and helpers of the preemptive priority task scheduler.
package ppts_pkg;

	localparam int MAX_TASKS_DEF = 16;
	localparam int TIME_BITS_DEF = 22;

	localparam int ARRIVAL_W = 16;
	localparam int BURST_W   = 16;
	localparam int PRIO_W    = 8;
	localparam int FIELD_W   = 22;
	localparam int TASK_NR_W = 5;
	localparam int STATUS_W  = 2;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 120;

	localparam logic [STATUS_W-1:0] STAT_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL       = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_ZERO_BURST = 2'd2;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	// Input payload, last member in the lowest bits.
	typedef struct packed {
		logic [PRIO_W-1:0]    prio;
		logic [BURST_W-1:0]   burst;
		logic [ARRIVAL_W-1:0] arrival;
	} in_t;

	// Result payload, last member in the lowest bits.
	typedef struct packed {
		logic                  pad;
		logic                  all_done;
		logic [FIELD_W-1:0]    response_time;
		logic [FIELD_W-1:0]    waiting_time;
		logic [FIELD_W-1:0]    turnaround_time;
		logic [FIELD_W-1:0]    completion_time;
		logic                  task_finished;
		logic [FIELD_W-1:0]    tick_time;
		logic [TASK_NR_W-1:0]  running_task;
		logic [STATUS_W-1:0]   status;
	} out_t;

	// Fixed-width part of one table entry.
	typedef struct packed {
		logic [ARRIVAL_W-1:0] arrival;
		logic [BURST_W-1:0]   burst;
		logic [PRIO_W-1:0]    prio;
		logic [BURST_W-1:0]   remaining;
		logic                 started;
	} task_t;

	typedef struct packed {
		logic scan_start;
		logic wr_en;
	} tbl_ctrl_t;

	typedef struct packed {
		logic scan_done;
		logic found;
	} tbl_stat_t;

	function automatic logic [31:0] sub_floor(input logic [31:0] a, input logic [31:0] b);
		sub_floor = (a >= b) ? (a - b) : 32'd0;
	endfunction

	function automatic logic [FIELD_W-1:0] to_field(input logic [31:0] v);
		to_field = v[FIELD_W-1:0];
	endfunction

endpackage

// ----- rtl/ppts_table.sv -----
// Task table memory with the sequential highest-priority scan.
module ppts_table #(
	parameter int MAX_TASKS = ppts_pkg::MAX_TASKS_DEF,
	parameter int TIME_BITS = ppts_pkg::TIME_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  ppts_pkg::tbl_ctrl_t                     ctrl,
	input  logic [$clog2(MAX_TASKS+1)-1:0]          loaded_count,
	input  logic [TIME_BITS-1:0]                    cur_time,
	input  logic [((MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1)-1:0] wr_addr,
	input  ppts_pkg::task_t                         wr_task,
	input  logic [TIME_BITS-1:0]                    wr_fr,
	output ppts_pkg::tbl_stat_t                     stat,
	output logic [((MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1)-1:0] best_idx,
	output ppts_pkg::task_t                         best_task,
	output logic [TIME_BITS-1:0]                    best_fr
);

	localparam int CNT_W  = $clog2(MAX_TASKS + 1);
	localparam int IDX_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int TASK_W = $bits(ppts_pkg::task_t);
	localparam int ENT_W  = TASK_W + TIME_BITS;

	logic [ENT_W-1:0] mem [MAX_TASKS];

	logic             scanning_q;
	logic [CNT_W-1:0] cnt_q;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic [ENT_W-1:0] rd_data_s1;
	ppts_pkg::task_t  rd_task;
	logic [TIME_BITS-1:0] rd_fr;
	logic             found_q;
	logic [IDX_W-1:0] best_idx_q;
	ppts_pkg::task_t  best_task_q;
	logic [TIME_BITS-1:0] best_fr_q;
	logic             ready_w;
	logic             win;
	logic             scan_done;

	assign rd_en   = scanning_q && (cnt_q != loaded_count);
	assign rd_addr = cnt_q[IDX_W-1:0];
	assign rd_task = rd_data_s1[ENT_W-1:TIME_BITS];
	assign rd_fr   = rd_data_s1[TIME_BITS-1:0];

	// ready: arrived and work left; strict greater keeps the lower index on a tie
	assign ready_w = (32'(rd_task.arrival) <= 32'(cur_time)) && (rd_task.remaining != '0);
	assign win     = rd_vld_s1 && ready_w && (!found_q || (rd_task.prio > best_task_q.prio));
	assign scan_done = scanning_q && (cnt_q == loaded_count) && !rd_vld_s1;

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[wr_addr] <= {wr_task, wr_fr};
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
		rd_idx_s1 <= rd_addr;
		if (win) begin
			best_idx_q  <= rd_idx_s1;
			best_task_q <= rd_task;
			best_fr_q   <= rd_fr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scanning_q <= 1'b0;
			cnt_q      <= '0;
			rd_vld_s1  <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (ctrl.scan_start) begin
				scanning_q <= 1'b1;
				cnt_q      <= '0;
				found_q    <= 1'b0;
			end else begin
				if (rd_en) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (win) begin
					found_q <= 1'b1;
				end
				if (scan_done) begin
					scanning_q <= 1'b0;
				end
			end
		end
	end

	assign stat.scan_done = scan_done;
	assign stat.found     = found_q;
	assign best_idx       = best_idx_q;
	assign best_task      = best_task_q;
	assign best_fr        = best_fr_q;

endmodule

// ----- rtl/preemptive_priority_task_scheduler_unit.sv -----
// Top level of the preemptive priority task scheduler.
//
//  channel  | direction | payload
//  ---------+-----------+------------------------------------------------------
//  s_*      | in        | tuser: action; tdata: arrival, burst, priority
//  m_*      | out       | tdata: status, running task, tick time, finish flag,
//           |           |        completion, turnaround, waiting, response, all done
//
// A load passes from the transfer through the finish state to the result. A tick
// starts a scan that reads one table entry per cycle through the single read port
// of the task memory; then the last entry is evaluated, the winner's arithmetic is
// settled, and the finish state writes back and registers the result.
// Reset clears time, counters and control; the table needs no clearing pass,
// since only entries below the load count are ever read.
// Input is taken only while idle; a waiting result does not block that transfer,
// but the next result is held back until the output register is free.
module preemptive_priority_task_scheduler_unit #(
	parameter int MAX_TASKS = ppts_pkg::MAX_TASKS_DEF,
	parameter int TIME_BITS = ppts_pkg::TIME_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [15:0] arrival_time, [31:16] burst_length, [39:32] task_priority
	input  logic [ppts_pkg::IN_DATA_W-1:0]    s_tdata,
	// [0] action
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [1:0] status, [6:2] running_task, [28:7] tick_time, [29] task_finished,
	// [51:30] completion_time, [73:52] turnaround_time, [95:74] waiting_time,
	// [117:96] response_time, [118] all_done, [119] zero
	output logic [ppts_pkg::OUT_DATA_W-1:0]   m_tdata
);

	localparam int CNT_W = $clog2(MAX_TASKS + 1);
	localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam logic [CNT_W-1:0]     MAX_CNT  = CNT_W'(MAX_TASKS);
	localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

	ppts_pkg::state_t state_q, state_d;

	// latched input item
	logic                 act_q;
	ppts_pkg::in_t        in_q;
	ppts_pkg::in_t        in_w;

	// scheduler state
	logic [TIME_BITS-1:0] cur_time_q;
	logic [CNT_W-1:0]     loaded_q;
	logic [CNT_W-1:0]     completed_q;

	// winner arithmetic, settled the cycle the scan ends
	logic                 found_q;
	logic [TIME_BITS-1:0] nxt_time_q;
	logic [ppts_pkg::BURST_W-1:0] rem_q;
	logic [TIME_BITS-1:0] fr_q;
	logic [ppts_pkg::BURST_W:0]   sum_q;

	// output register
	logic                 m_tvalid_q;
	ppts_pkg::out_t       out_q;
	ppts_pkg::out_t       out_d;

	// table interface
	ppts_pkg::tbl_ctrl_t  tbl_ctrl;
	ppts_pkg::tbl_stat_t  tbl_stat;
	logic                 scan_start;
	logic                 tbl_wr_en;
	logic [IDX_W-1:0]     wr_addr;
	ppts_pkg::task_t      wr_task;
	logic [TIME_BITS-1:0] wr_fr;
	logic [IDX_W-1:0]     best_idx;
	ppts_pkg::task_t      best_task;
	logic [TIME_BITS-1:0] best_fr;

	logic                 in_xfer;
	logic                 out_free;
	logic                 finish_go;
	logic                 load_ok;
	logic                 fin_w;
	logic [CNT_W-1:0]     loaded_nxt;
	logic [CNT_W-1:0]     completed_nxt;
	logic [31:0]          tat_w;
	logic [31:0]          wt_w;
	logic [31:0]          run_w;
	logic [31:0]          fr_w;
	logic [ppts_pkg::STATUS_W-1:0] status_w;

	assign in_w     = s_tdata;
	assign in_xfer  = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign tbl_ctrl = '{scan_start: scan_start, wr_en: tbl_wr_en};

	ppts_table #(
		.MAX_TASKS (MAX_TASKS),
		.TIME_BITS (TIME_BITS)
	) u_table (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (tbl_ctrl),
		.loaded_count (loaded_q),
		.cur_time     (cur_time_q),
		.wr_addr      (wr_addr),
		.wr_task      (wr_task),
		.wr_fr        (wr_fr),
		.stat         (tbl_stat),
		.best_idx     (best_idx),
		.best_task    (best_task),
		.best_fr      (best_fr)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppts_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake
	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		scan_start = 1'b0;
		finish_go  = 1'b0;
		case (state_q)
			ppts_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (s_tuser == ppts_pkg::ACT_TICK) begin
						scan_start = 1'b1;
						state_d    = ppts_pkg::S_SCAN;
					end else begin
						state_d = ppts_pkg::S_FINISH;
					end
				end
			end
			ppts_pkg::S_SCAN: begin
				if (tbl_stat.scan_done) begin
					state_d = ppts_pkg::S_FINISH;
				end
			end
			ppts_pkg::S_FINISH: begin
				// hold the result until the output register drains
				if (out_free) begin
					finish_go = 1'b1;
					state_d   = ppts_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ppts_pkg::S_IDLE;
			end
		endcase
	end

	// load decisions: full table is checked before zero burst
	always_comb begin
		if (loaded_q == MAX_CNT) begin
			status_w = ppts_pkg::STAT_FULL;
		end else if (in_q.burst == '0) begin
			status_w = ppts_pkg::STAT_ZERO_BURST;
		end else begin
			status_w = ppts_pkg::STAT_OK;
		end
	end

	assign load_ok = (act_q == ppts_pkg::ACT_LOAD) && (status_w == ppts_pkg::STAT_OK);
	assign fin_w   = (act_q == ppts_pkg::ACT_TICK) && found_q && (rem_q == '0);

	// turnaround and waiting in parallel: waiting floors at completion - (arrival + burst)
	assign tat_w = ppts_pkg::sub_floor(32'(nxt_time_q), 32'(best_task.arrival));
	assign wt_w  = ppts_pkg::sub_floor(32'(nxt_time_q), 32'(sum_q));
	assign run_w = 32'(best_idx) + 32'd1;
	assign fr_w  = ppts_pkg::sub_floor(32'(cur_time_q), 32'(best_task.arrival));

	assign loaded_nxt    = load_ok ? (loaded_q + 1'b1) : loaded_q;
	assign completed_nxt = fin_w ? (completed_q + 1'b1) : completed_q;

	// table write-back: a new task on load, the updated winner on a tick
	always_comb begin
		tbl_wr_en = 1'b0;
		wr_addr   = best_idx;
		wr_task   = best_task;
		wr_fr     = fr_q;
		if (act_q == ppts_pkg::ACT_LOAD) begin
			tbl_wr_en         = finish_go && load_ok;
			wr_addr           = loaded_q[IDX_W-1:0];
			wr_task.arrival   = in_q.arrival;
			wr_task.burst     = in_q.burst;
			wr_task.prio      = in_q.prio;
			wr_task.remaining = in_q.burst;
			wr_task.started   = 1'b0;
			wr_fr             = '0;
		end else begin
			tbl_wr_en         = finish_go && found_q;
			wr_task.remaining = rem_q;
			wr_task.started   = 1'b1;
		end
	end

	// result assembly
	always_comb begin
		out_d                 = '0;
		out_d.tick_time       = ppts_pkg::to_field(32'(cur_time_q));
		out_d.all_done        = (completed_nxt == loaded_nxt);
		if (act_q == ppts_pkg::ACT_LOAD) begin
			out_d.status = status_w;
		end else begin
			if (found_q) begin
				out_d.running_task = run_w[ppts_pkg::TASK_NR_W-1:0];
			end
			if (fin_w) begin
				out_d.task_finished   = 1'b1;
				out_d.completion_time = ppts_pkg::to_field(32'(nxt_time_q));
				out_d.turnaround_time = ppts_pkg::to_field(tat_w);
				out_d.waiting_time    = ppts_pkg::to_field(wt_w);
				out_d.response_time   = ppts_pkg::to_field(32'(fr_q));
			end
		end
	end

	// payload latches: input item, winner arithmetic, result
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			act_q <= s_tuser;
			in_q  <= in_w;
		end
		if ((state_q == ppts_pkg::S_SCAN) && tbl_stat.scan_done) begin
			found_q    <= tbl_stat.found;
			nxt_time_q <= (cur_time_q == TIME_MAX) ? cur_time_q : (cur_time_q + 1'b1);
			rem_q      <= best_task.remaining - 1'b1;
			fr_q       <= best_task.started ? best_fr : fr_w[TIME_BITS-1:0];
			sum_q      <= {1'b0, best_task.arrival} + {1'b0, best_task.burst};
		end
		if (finish_go) begin
			out_q <= out_d;
		end
	end

	// control state: clock, counters, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_time_q  <= '0;
			loaded_q    <= '0;
			completed_q <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (finish_go) begin
				loaded_q    <= loaded_nxt;
				completed_q <= completed_nxt;
				m_tvalid_q  <= 1'b1;
				if (act_q == ppts_pkg::ACT_TICK) begin
					// advance the clock, saturating at its maximum
					cur_time_q <= nxt_time_q;
				end
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;

endmodule

// ----- verif/tb_top.sv -----
// Testbench for the preemptive priority task scheduler unit.
`timescale 1ns / 100ps

module tb_top;

	localparam int GAP_MAX       = 18;
	localparam int RANDOM_ITEMS  = 1150;
	localparam int SETTLE_CYCLES = 50;
	localparam int REPORT_LIMIT  = 10;
	localparam int TIME_W        = ppts_pkg::TIME_BITS_DEF;
	localparam int TASK_W        = ppts_pkg::TASK_NR_W;
	localparam logic [TIME_W-1:0] CLOCK_MAX = '1;

	logic                            clk;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [ppts_pkg::IN_DATA_W-1:0]  s_tdata;
	logic                            s_tuser;
	logic                            m_tvalid;
	logic                            m_tready;
	logic [ppts_pkg::OUT_DATA_W-1:0] m_tdata;

	// Scheduler image: clock, counters and task table as the block should hold them.
	logic [TIME_W-1:0]             sched_clock;
	int                            n_loaded;
	int                            n_done;
	logic [ppts_pkg::ARRIVAL_W-1:0] tab_arrival [ppts_pkg::MAX_TASKS_DEF];
	logic [ppts_pkg::BURST_W-1:0]   tab_burst   [ppts_pkg::MAX_TASKS_DEF];
	logic [ppts_pkg::PRIO_W-1:0]    tab_prio    [ppts_pkg::MAX_TASKS_DEF];
	logic [ppts_pkg::BURST_W-1:0]   tab_left    [ppts_pkg::MAX_TASKS_DEF];
	logic                           tab_started [ppts_pkg::MAX_TASKS_DEF];
	logic [ppts_pkg::FIELD_W-1:0]   tab_resp    [ppts_pkg::MAX_TASKS_DEF];

	ppts_pkg::out_t sched_reports_q[$];
	ppts_pkg::out_t got_report;
	ppts_pkg::out_t want_report;

	int  errors;
	int  mismatches;
	int  tx_left;
	bit  tx_calm;
	int  rx_left;
	bit  rx_calm;

	preemptive_priority_task_scheduler_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Draw an idle count for one item. Alternate between calm stretches with no
	// idling at all and noisy stretches with random gaps, so both show up.
	function automatic int draw_gap(inout int left, inout bit calm);
		if (left == 0) begin
			calm = ($urandom_range(0, 3) == 0);
			left = $urandom_range(8, 40);
		end
		left--;
		return calm ? 0 : $urandom_range(0, GAP_MAX);
	endfunction

	// Advance the scheduler image by one item and return the report it should give.
	function automatic ppts_pkg::out_t schedule_step(input logic act,
			input logic [ppts_pkg::ARRIVAL_W-1:0] arr,
			input logic [ppts_pkg::BURST_W-1:0] bur, input logic [ppts_pkg::PRIO_W-1:0] pri);
		ppts_pkg::out_t rep;
		int   best;
		bit   found;
		logic [TIME_W-1:0] tat;
		rep = '0;
		rep.status = ppts_pkg::STAT_OK;
		rep.tick_time = sched_clock;
		if (act == ppts_pkg::ACT_LOAD) begin
			// The full-table check wins over the zero-burst check.
			if (n_loaded >= ppts_pkg::MAX_TASKS_DEF) begin
				rep.status = ppts_pkg::STAT_FULL;
			end else if (bur == '0) begin
				rep.status = ppts_pkg::STAT_ZERO_BURST;
			end else begin
				tab_arrival[n_loaded] = arr;
				tab_burst[n_loaded]   = bur;
				tab_prio[n_loaded]    = pri;
				tab_left[n_loaded]    = bur;
				tab_started[n_loaded] = 1'b0;
				tab_resp[n_loaded]    = '0;
				n_loaded++;
			end
		end else begin
			found = 0;
			best = 0;
			// Strictly greater priority replaces the pick, so the lower index keeps a tie.
			for (int i = 0; i < n_loaded; i++) begin
				if (TIME_W'(tab_arrival[i]) <= sched_clock && tab_left[i] != '0) begin
					if (!found || tab_prio[i] > tab_prio[best]) begin
						best = i;
						found = 1;
					end
				end
			end
			if (found) begin
				if (!tab_started[best]) begin
					tab_started[best] = 1'b1;
					tab_resp[best] = (sched_clock >= TIME_W'(tab_arrival[best])) ?
						sched_clock - TIME_W'(tab_arrival[best]) : '0;
				end
				rep.running_task = TASK_W'(best + 1);
				tab_left[best] = tab_left[best] - 1'b1;
			end
			if (sched_clock != CLOCK_MAX)
				sched_clock = sched_clock + 1'b1;
			if (found && tab_left[best] == '0) begin
				n_done++;
				tat = (sched_clock >= TIME_W'(tab_arrival[best])) ?
					sched_clock - TIME_W'(tab_arrival[best]) : '0;
				rep.task_finished   = 1'b1;
				rep.completion_time = sched_clock;
				rep.turnaround_time = tat;
				rep.waiting_time    = (tat >= TIME_W'(tab_burst[best])) ?
					tat - TIME_W'(tab_burst[best]) : '0;
				rep.response_time   = tab_resp[best];
			end
		end
		rep.all_done = (n_done == n_loaded);
		return rep;
	endfunction

	// Offer one item and hold it until the transfer; then record the expected report.
	// Valid stays high into the next item when no gap follows, so it is never
	// lowered and raised in the same step.
	task automatic send_item(input logic act, input logic [ppts_pkg::ARRIVAL_W-1:0] arr,
			input logic [ppts_pkg::BURST_W-1:0] bur, input logic [ppts_pkg::PRIO_W-1:0] pri);
		int gap;
		gap = draw_gap(tx_left, tx_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {pri, bur, arr};
		do
			@(posedge clk);
		while (!s_tready);
		sched_reports_q.push_back(schedule_step(act, arr, bur, pri));
	endtask

	// Issue ticks with random payload bits, which the block must ignore.
	task automatic run_ticks(input int count);
		for (int i = 0; i < count; i++)
			send_item(ppts_pkg::ACT_TICK, 16'($urandom), 16'($urandom), 8'($urandom));
	endtask

	// Drop valid and hold off until every outstanding report has come back.
	task automatic drain_reports();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sched_reports_q.size() != 0)
			@(posedge clk);
	endtask

	// Ticks on an empty table stay idle, report task 0, and still advance time.
	task automatic test_empty_ticks();
		run_ticks(2);
	endtask

	// Zero-burst loads are dropped, at both extremes of the other fields.
	task automatic test_zero_burst();
		send_item(ppts_pkg::ACT_LOAD, 16'hFFFF, 16'h0000, 8'hFF);
		send_item(ppts_pkg::ACT_LOAD, 16'h0000, 16'h0000, 8'h00);
	endtask

	// Equal priorities resolve to the lower index; a high-priority task with a
	// future arrival preempts once it arrives; a late load of a task whose
	// arrival lies in the past joins the table.
	task automatic test_priority_rules();
		send_item(ppts_pkg::ACT_LOAD, 16'd0, 16'd3, 8'd5);
		send_item(ppts_pkg::ACT_LOAD, 16'd0, 16'd2, 8'd5);
		send_item(ppts_pkg::ACT_LOAD, 16'(sched_clock + 3), 16'd2, 8'hFF);
		run_ticks(2);
		send_item(ppts_pkg::ACT_LOAD, 16'd0, 16'd1, 8'd0);
		run_ticks(9);
	endtask

	// Mostly ticks, with loads arriving near the current time or earlier until the table fills;
	// once full, loads carry arbitrary fields and must all be dropped.
	task automatic test_random_traffic();
		logic [ppts_pkg::ARRIVAL_W-1:0] arr;
		logic [ppts_pkg::BURST_W-1:0]   bur;
		logic [ppts_pkg::PRIO_W-1:0]    pri;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n_loaded < ppts_pkg::MAX_TASKS_DEF && $urandom_range(0, 5) == 0) begin
				if ($urandom_range(0, 3) != 0)
					arr = 16'(sched_clock + $urandom_range(0, 30));
				else
					arr = 16'($urandom_range(0, sched_clock));
				case ($urandom_range(0, 19))
					0: bur = '0;
					1: bur = 16'($urandom_range(26, 200));
					default: bur = 16'($urandom_range(1, 25));
				endcase
				pri = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
				send_item(ppts_pkg::ACT_LOAD, arr, bur, pri);
			end else if (n_loaded == ppts_pkg::MAX_TASKS_DEF && $urandom_range(0, 9) == 0) begin
				send_item(ppts_pkg::ACT_LOAD, 16'($urandom), 16'($urandom), 8'($urandom));
			end else begin
				run_ticks(1);
			end
		end
	endtask

	// Fill what is left of the table, show that a full table drops even a
	// zero-burst load, then tick until every task has completed.
	task automatic test_full_table();
		int guard;
		while (n_loaded < ppts_pkg::MAX_TASKS_DEF)
			send_item(ppts_pkg::ACT_LOAD, 16'(sched_clock + $urandom_range(0, 5)),
				16'($urandom_range(1, 4)), 8'($urandom));
		send_item(ppts_pkg::ACT_LOAD, 16'hFFFF, 16'hFFFF, 8'hFF);
		send_item(ppts_pkg::ACT_LOAD, 16'h0000, 16'h0000, 8'h00);
		guard = 0;
		while (n_done < n_loaded && guard < 4000) begin
			run_ticks(1);
			guard++;
		end
		run_ticks(2);
	endtask

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			errors++;
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("mismatch in %s: expected %0d, got %0d", name, want, got);
		end
	endtask

	// Receiver: draw a stall before each report, then hold ready until a transfer.
	initial begin
		rx_left = 0;
		rx_calm = 0;
		forever begin
			int stall;
			stall = draw_gap(rx_left, rx_calm);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do
				@(posedge clk);
			while (!m_tvalid);
		end
	end

	// Compare each transferred report with the oldest expectation, field by field.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_report = m_tdata;
			if (sched_reports_q.size() == 0) begin
				errors++;
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected report: %h", m_tdata);
			end else begin
				want_report = sched_reports_q.pop_front();
				check_field("status", want_report.status, got_report.status);
				check_field("running_task", want_report.running_task,
					got_report.running_task);
				check_field("tick_time", want_report.tick_time, got_report.tick_time);
				check_field("task_finished", want_report.task_finished,
					got_report.task_finished);
				check_field("completion_time", want_report.completion_time,
					got_report.completion_time);
				check_field("turnaround_time", want_report.turnaround_time,
					got_report.turnaround_time);
				check_field("waiting_time", want_report.waiting_time,
					got_report.waiting_time);
				check_field("response_time", want_report.response_time,
					got_report.response_time);
				check_field("all_done", want_report.all_done, got_report.all_done);
			end
		end
	end

	// Stop a hung run long after the slowest correct one would have ended.
	initial begin
		#10_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		errors = 0;
		mismatches = 0;
		tx_left = 0;
		tx_calm = 0;
		sched_clock = '0;
		n_loaded = 0;
		n_done = 0;
		s_tvalid <= 1'b0;
		s_tuser  <= ppts_pkg::ACT_LOAD;
		s_tdata  <= '0;
		arst_n   <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n   <= 1'b1;
		@(posedge clk);

		test_empty_ticks();
		test_zero_burst();
		test_priority_rules();
		drain_reports();
		test_random_traffic();
		test_full_table();

		// Drain the tail, then give the block time to show any stray report.
		drain_reports();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/ppts_pkg.sv
rtl/ppts_table.sv
rtl/preemptive_priority_task_scheduler_unit.sv
verif/tb_top.sv
